// ===== sv/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

  localparam int MAX_FREQ_DEF = 64;

  localparam int THETA_W   = 21;
  localparam int FREQ_W    = 7;
  localparam int POS_W     = 32;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 8;
  localparam int Q15_W     = 16;
  localparam int INV_W     = 32;
  localparam int ADDR_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 2'd1;

  localparam logic [THETA_W-1:0] THETA_RST = 21'd10000;
  localparam logic [FREQ_W-1:0]  FREQ_RST  = 7'd16;

  // angle reduction
  localparam int PROD_W    = 63;
  localparam int RED_W     = 51;
  localparam int MOD_STEPS = 13;
  localparam logic [RED_W-1:0] TWO_PI_Q48 = 51'h6487ED5110B46;

  // CORDIC, Q6.30 in a 36-bit signed word
  localparam int ANG_W        = 36;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sh0C90FDAA2;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sh06487ED51;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sh1921FB544;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 36'sh026DD3B6A;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;
  } meta_t;

  // flag: negative position in reduction, result flip in CORDIC
  typedef struct packed {
    logic  flag;
    meta_t meta;
  } tag_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [INV_W-1:0]  data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    BLD_SETUP,
    BLD_LOG,
    BLD_DIV,
    BLD_EXP,
    BLD_WRITE,
    BLD_IDLE
  } bld_state_t;

endpackage
`default_nettype wire

// ===== sv/rsc_table_build.sv =====
`default_nettype none
module rsc_table_build import rsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [THETA_W-1:0] theta,
  input  logic [FREQ_W-1:0]  eff,
  output logic               busy,
  output tbl_wr_t            wr
);

  localparam int NUM_W = 44;
  localparam int LG_W  = 37;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] one;
    v   = v_in;
    res = '0;
    one = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + one) begin
        v   = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-(j+1)) in Q0.32, j = 0..31
  function automatic logic [32*32-1:0] root_table();
    logic [32*32-1:0] t;
    logic [63:0]      c;
    t = '0;
    c = isqrt64(64'd1 << 63);
    for (int j = 0; j < 32; j++) begin
      t[j*32 +: 32] = c[31:0];
      c = isqrt64(c << 32);
    end
    return t;
  endfunction

  localparam logic [32*32-1:0] ROOTS = root_table();

  bld_state_t       state_r, state_nxt;
  logic [5:0]       cnt_r;
  logic [FREQ_W-1:0] eff_r;
  logic [4:0]       e_r;
  logic [30:0]      m_r;
  logic [31:0]      f_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] div_r;
  logic [FREQ_W-1:0] rem_r;
  logic [32:0]      acc_r;
  logic [ADDR_W-1:0] k_r;

  logic [4:0]       e_c;
  logic [30:0]      m0;
  logic [61:0]      sq;
  logic [31:0]      m2;
  logic [FREQ_W:0]  rem_sh;
  logic [FREQ_W:0]  rem_sub;
  logic             qbit;
  logic [64:0]      eprod;
  logic [32:0]      shifted;
  logic [INV_W-1:0] inv_val;
  logic [NUM_W-1:0] num_next;
  logic             last_k;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < THETA_W; i++) begin
      if (theta[i]) e_c = 5'(i);
    end
  end

  assign m0       = 31'(31'(theta) << (5'd30 - e_c));
  assign sq       = 62'(m_r) * 62'(m_r);
  assign m2       = sq[61:30];
  assign rem_sh   = {rem_r, div_r[NUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, eff_r};
  assign qbit     = rem_sh >= {1'b0, eff_r};
  assign eprod    = 65'(acc_r) * 65'(ROOTS[cnt_r[4:0]*32 +: 32]);
  assign shifted  = acc_r >> div_r[36:32];
  assign inv_val  = shifted[32] ? '1 : shifted[31:0];
  assign num_next = num_r + NUM_W'({e_r, f_r});
  assign last_k   = (k_r + 8'd1) == ADDR_W'(eff_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BLD_SETUP: state_nxt = BLD_LOG;
      BLD_LOG:   if (cnt_r == 6'd31) state_nxt = BLD_DIV;
      BLD_DIV:   if (cnt_r == 6'd43) state_nxt = BLD_EXP;
      BLD_EXP:   if (cnt_r == 6'd31) state_nxt = BLD_WRITE;
      BLD_WRITE: state_nxt = last_k ? BLD_IDLE : BLD_DIV;
      BLD_IDLE:  state_nxt = BLD_IDLE;
      default:   state_nxt = BLD_IDLE;
    endcase
    if (start) state_nxt = BLD_SETUP;
  end

  always_comb begin
    busy    = state_r != BLD_IDLE;
    wr.we   = state_r == BLD_WRITE;
    wr.addr = k_r;
    wr.data = inv_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BLD_SETUP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BLD_SETUP || state_r == BLD_WRITE || state_r == BLD_IDLE) begin
        cnt_r <= '0;
      end else if ((state_r == BLD_DIV && cnt_r == 6'd43) ||
                   (state_r != BLD_DIV && cnt_r == 6'd31)) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BLD_SETUP: begin
        eff_r <= eff;
        e_r   <= e_c;
        m_r   <= m0;
        f_r   <= '0;
        k_r   <= '0;
        num_r <= '0;
        div_r <= '0;
        rem_r <= '0;
      end
      BLD_LOG: begin
        if (m2[31]) begin
          m_r <= m2[31:1];
          f_r <= {f_r[30:0], 1'b1};
        end else begin
          m_r <= m2[30:0];
          f_r <= {f_r[30:0], 1'b0};
        end
      end
      BLD_DIV: begin
        rem_r <= qbit ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
        div_r <= {div_r[NUM_W-2:0], qbit};
        acc_r <= 33'h1_0000_0000;
      end
      BLD_EXP: begin
        if (div_r[31]) acc_r <= eprod[64:32];
        div_r <= {div_r[NUM_W-1:32], div_r[30:0], 1'b0};
      end
      BLD_WRITE: begin
        k_r   <= k_r + 8'd1;
        num_r <= num_next;
        div_r <= num_next;
        rem_r <= '0;
      end
      BLD_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  // upper quotient bits stay zero since the quotient stays below log2(theta)
  logic unused_hi;
  assign unused_hi = ^div_r[NUM_W-1:LG_W];

endmodule
`default_nettype wire

// ===== sv/rsc_mod_cell.sv =====
`default_nettype none
module rsc_mod_cell import rsc_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [PROD_W-1:0] in_rem,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_rem,
  output tag_t              out_tag
);

  localparam logic [PROD_W-1:0] STEP_VAL = PROD_W'(TWO_PI_Q48) << SHIFT;

  logic              valid_r;
  logic [PROD_W-1:0] rem_r;
  tag_t              tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= (in_rem >= STEP_VAL) ? in_rem - STEP_VAL : in_rem;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_tag   = tag_r;

endmodule
`default_nettype wire

// ===== sv/rsc_cordic_cell.sv =====
`default_nettype none
module rsc_cordic_cell import rsc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_x,
  input  logic signed [ANG_W-1:0] in_y,
  input  logic signed [ANG_W-1:0] in_a,
  input  tag_t                    in_tag,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_x,
  output logic signed [ANG_W-1:0] out_y,
  output logic signed [ANG_W-1:0] out_a,
  output tag_t                    out_tag
);

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      0:  v = 36'sh03243F6A8;
      1:  v = 36'sh01DAC6705;
      2:  v = 36'sh00FADBAFC;
      3:  v = 36'sh007F56EA6;
      4:  v = 36'sh003FEAB76;
      5:  v = 36'sh001FFD55B;
      6:  v = 36'sh000FFFAAA;
      7:  v = 36'sh0007FFF55;
      8:  v = 36'sh0003FFFEA;
      9:  v = 36'sh0001FFFFD;
      10: v = 36'sh0000FFFFF;
      11: v = 36'sh00007FFFF;
      12: v = 36'sh00003FFFF;
      default: v = ANG_W'(36'sd1 <<< (30 - i));
    endcase
    return v;
  endfunction

  localparam logic signed [ANG_W-1:0] AT = atan_q30(STEP);

  logic                    valid_r;
  logic signed [ANG_W-1:0] x_r, y_r, a_r;
  tag_t                    tag_r;
  logic signed [ANG_W-1:0] dx, dy;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!in_a[ANG_W-1]) begin
        x_r <= in_x - dx;
        y_r <= in_y + dy;
        a_r <= in_a - AT;
      end else begin
        x_r <= in_x + dx;
        y_r <= in_y - dy;
        a_r <= in_a + AT;
      end
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_a     = a_r;
  assign out_tag   = tag_r;

endmodule
`default_nettype wire

// ===== sv/rope_sin_cos_table_gen.sv =====
`default_nettype none
// Rotary position embedding sin/cos generator for three axes per row. Each
// accepted position (signed Q16.16) yields freq_dim results, one per frequency,
// with row, column = axis*freq_dim + k, cos and sin in Q1.15 and a last flag.
// The issue stage sends one result per cycle, unless stalled, into a pipeline
// (table read, multiply, 13 reduction cells, fold, 30 CORDIC cells, output
// register) and takes no new item before its last frequency issues. After reset
// and each write of either register a serial log2/divide/exp2 unit rebuilds
// the inverse frequency table; no item is taken meanwhile. The user must write
// configuration only with the pipeline drained; the block does not enforce it.
module rope_sin_cos_table_gen import rsc_pkg::*; #(
  parameter int MAX_FREQ = MAX_FREQ_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row_index,
  output logic [COL_W-1:0]        out_column,
  output logic signed [Q15_W-1:0] out_cosine_value,
  output logic signed [Q15_W-1:0] out_sine_value,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [THETA_W-1:0]      cfg_wdata
);

  localparam int KW = (MAX_FREQ > 1) ? $clog2(MAX_FREQ) : 1;

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W:0]    s;
    logic signed [ANG_W-15:0] r;
    s = {v[ANG_W-1], v} + (ANG_W+1)'(1 << 14);
    r = s[ANG_W:15];
    if (r > 22'sd32767) return 16'sh7FFF;
    else if (r < -22'sd32768) return 16'sh8000;
    else return r[Q15_W-1:0];
  endfunction

  // configuration
  logic [THETA_W-1:0] theta_r;
  logic [FREQ_W-1:0]  freq_r;
  logic               bld_start;
  logic [THETA_W-1:0] theta_eff;
  logic [FREQ_W-1:0]  eff;
  logic               bld_busy;
  tbl_wr_t            tbl_wr;

  assign bld_start = cfg_we && (cfg_index == CFG_THETA || cfg_index == CFG_FREQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RST;
      freq_r  <= FREQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THETA: theta_r <= cfg_wdata;
        CFG_FREQ:  freq_r  <= cfg_wdata[FREQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign theta_eff = (theta_r == '0) ? THETA_W'(1) : theta_r;
  assign eff = (freq_r == '0) ? FREQ_W'(1) :
               (9'(freq_r) > 9'(MAX_FREQ)) ? FREQ_W'(MAX_FREQ) : freq_r;

  rsc_table_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bld_start),
    .theta (theta_eff),
    .eff   (eff),
    .busy  (bld_busy),
    .wr    (tbl_wr)
  );

  // issue
  logic                    adv;
  logic                    in_acc;
  logic                    iss_act_r;
  logic [KW-1:0]           k_r;
  logic [FREQ_W-1:0]       eff_r;
  logic signed [POS_W-1:0] pos_r;
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        item_row_r;
  logic [1:0]              axis_r;
  logic [ROW_W-1:0]        row_cnt_r;
  logic [COL_W-1:0]        col_base;
  logic                    last_k;

  assign in_ready = !iss_act_r && !bld_busy && !cfg_we;
  assign in_acc   = in_valid && in_ready;
  assign last_k   = (9'(k_r) + 9'd1) == 9'(eff_r);

  always_comb begin
    unique case (axis_r)
      2'd0:    col_base = '0;
      2'd1:    col_base = COL_W'(eff);
      2'd2:    col_base = COL_W'({eff, 1'b0});
      default: col_base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      axis_r    <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      iss_act_r <= 1'b1;
      if (axis_r == 2'd2) begin
        axis_r    <= '0;
        row_cnt_r <= row_cnt_r + 16'd1;
      end else begin
        axis_r <= axis_r + 2'd1;
      end
    end else if (iss_act_r && adv && last_k) begin
      iss_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      k_r        <= '0;
      eff_r      <= eff;
      pos_r      <= in_position;
      col_r      <= col_base;
      item_row_r <= row_cnt_r;
    end else if (iss_act_r && adv) begin
      k_r   <= k_r + KW'(1);
      col_r <= col_r + 8'd1;
    end
  end

  // table memory
  logic [INV_W-1:0] inv_mem [MAX_FREQ];
  logic [INV_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (tbl_wr.we) inv_mem[tbl_wr.addr[KW-1:0]] <= tbl_wr.data;
    if (adv && iss_act_r) rd_r <= inv_mem[k_r];
  end

  // read stage and multiply stage
  logic                    s0_v_r, s1_v_r;
  tag_t                    s0_tag_r, s1_tag_r;
  logic signed [POS_W-1:0] s0_pos_r;
  logic [POS_W-1:0]        mag;
  logic [63:0]             prod;
  logic [PROD_W-1:0]       prod_r;

  assign mag  = s0_pos_r[POS_W-1] ? (~s0_pos_r + 32'd1) : s0_pos_r;
  assign prod = 64'(mag) * 64'(rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= iss_act_r;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_tag_r.flag        <= pos_r[POS_W-1];
      s0_tag_r.meta.row    <= item_row_r;
      s0_tag_r.meta.column <= col_r;
      s0_tag_r.meta.last   <= last_k;
      s0_pos_r             <= pos_r;
      s1_tag_r             <= s0_tag_r;
      prod_r               <= prod[PROD_W-1:0];
    end
  end

  // modulo 2*pi
  logic              md_val [MOD_STEPS+1];
  logic [PROD_W-1:0] md_rem [MOD_STEPS+1];
  tag_t              md_tag [MOD_STEPS+1];

  assign md_val[0] = s1_v_r;
  assign md_rem[0] = prod_r;
  assign md_tag[0] = s1_tag_r;

  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
    rsc_mod_cell #(.SHIFT(MOD_STEPS - 1 - g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (md_val[g]),
      .in_rem    (md_rem[g]),
      .in_tag    (md_tag[g]),
      .out_valid (md_val[g+1]),
      .out_rem   (md_rem[g+1]),
      .out_tag   (md_tag[g+1])
    );
  end

  // sign, fold into [-pi/2, pi/2]
  logic [RED_W-1:0]        rr;
  logic signed [ANG_W-1:0] a0, a1, a2;
  logic                    flip;
  logic                    fd_v_r;
  logic signed [ANG_W-1:0] fd_a_r;
  tag_t                    fd_tag_r;
  tag_t                    fold_tag;

  always_comb begin
    rr = md_rem[MOD_STEPS][RED_W-1:0];
    if (md_tag[MOD_STEPS].flag && rr != '0) rr = TWO_PI_Q48 - rr;
    a0 = ANG_W'(rr[RED_W-1:18]);
    a1 = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
    flip = 1'b0;
    a2 = a1;
    if (a1 > HALF_PI_Q30) begin
      a2 = a1 - PI_Q30;
      flip = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      a2 = a1 + PI_Q30;
      flip = 1'b1;
    end
    fold_tag      = md_tag[MOD_STEPS];
    fold_tag.flag = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_v_r <= 1'b0;
    end else if (adv) begin
      fd_v_r <= md_val[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_a_r   <= a2;
      fd_tag_r <= fold_tag;
    end
  end

  // CORDIC row
  logic                    cv [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ca [CORDIC_STEPS+1];
  tag_t                    ct [CORDIC_STEPS+1];

  assign cv[0] = fd_v_r;
  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign ca[0] = fd_a_r;
  assign ct[0] = fd_tag_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rsc_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_a      (ca[i]),
      .in_tag    (ct[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_a     (ca[i+1]),
      .out_tag   (ct[i+1])
    );
  end

  // output register
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic [COL_W-1:0]        out_col_r;
  logic signed [Q15_W-1:0] out_cos_r, out_sin_r;
  logic                    out_last_r;
  logic signed [ANG_W-1:0] xf, yf;
  logic                    unused_a;

  assign adv = !out_valid_r || out_ready;
  assign xf  = ct[CORDIC_STEPS].flag ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign yf  = ct[CORDIC_STEPS].flag ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
  assign unused_a = ^ca[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r  <= ct[CORDIC_STEPS].meta.row;
      out_col_r  <= ct[CORDIC_STEPS].meta.column;
      out_last_r <= ct[CORDIC_STEPS].meta.last;
      out_cos_r  <= to_q15(xf);
      out_sin_r  <= to_q15(yf);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_column       = out_col_r;
  assign out_cosine_value = out_cos_r;
  assign out_sine_value   = out_sin_r;
  assign out_last         = out_last_r;

  a_no_accept_while_building: assert property (@(posedge clk) disable iff (!rst_n)
    bld_busy |-> !in_ready)
    else $error("item accepted during table build");

  a_issue_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (iss_act_r && k_r == '0))
    else $error("issue did not start at frequency zero");

  a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!rst_n)
    bld_start |=> bld_busy)
    else $error("register write did not start a table build");

endmodule
`default_nettype wire
